// ===== rtl/core/ps2sd_pkg.sv =====
`default_nettype none
package ps2sd_pkg;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [6:0] BASE_MASK   = 7'h7F;
	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [6:0] LSHIFT_CODE = 7'h2A;
	localparam logic [6:0] RSHIFT_CODE = 7'h36;
	localparam int unsigned TABLE_LEN  = 58;
	localparam int unsigned MAP_DEPTH  = 256;
	localparam int unsigned MAP_AW     = 8;

	localparam logic KIND_SCAN  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [6:0] PLAIN_CHARS [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h01,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h02, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h03, 7'h2A, 7'h04, 7'h20
	};

	localparam logic [6:0] SHIFTED_CHARS [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h01,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h02, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h03, 7'h2A, 7'h04, 7'h20
	};

	typedef struct packed {
		logic              we;
		logic [MAP_AW-1:0] waddr;
		logic              wdata;
		logic              re;
		logic [MAP_AW-1:0] raddr;
	} map_req_t;

	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [6:0] key_code;
		logic [6:0] char_value;
	} dec_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ps2sd_ram.sv =====
`default_nettype none
module ps2sd_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ps2sd_decode.sv =====
`default_nettype none
module ps2sd_decode
	import ps2sd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        accept,
	input  wire        kind,
	input  wire [7:0]  code_byte,
	input  wire [7:0]  query_key,
	output logic       busy,
	output map_req_t   map_req,
	output dec_res_t   res
);

	logic              prefix_q;
	logic              shift_q;
	logic              clr_busy_q;
	logic [MAP_AW-1:0] clr_addr_q;

	logic              is_scan;
	logic              is_prefix;
	logic              released;
	logic [6:0]        base;
	logic              shift_key;
	logic              shift_nxt;
	logic              in_table;
	logic [6:0]        ch;

	always_comb begin
		is_scan   = (kind == KIND_SCAN);
		is_prefix = (code_byte == PREFIX_BYTE);
		released  = |(code_byte & RELEASE_BIT);
		base      = code_byte[6:0] & BASE_MASK;
		shift_key = !prefix_q && (base == LSHIFT_CODE || base == RSHIFT_CODE);
		shift_nxt = shift_key ? !released : shift_q;
		in_table  = ({25'd0, base} < TABLE_LEN);
		ch        = 7'd0;
		if (in_table) begin
			ch = shift_nxt ? SHIFTED_CHARS[base[5:0]] : PLAIN_CHARS[base[5:0]];
		end
	end

	always_comb begin
		map_req.re    = accept && !is_scan;
		map_req.raddr = query_key;
		if (clr_busy_q) begin
			map_req.we    = 1'b1;
			map_req.waddr = clr_addr_q;
			map_req.wdata = 1'b0;
		end else begin
			map_req.we    = accept && is_scan && !is_prefix;
			map_req.waddr = {prefix_q, base};
			map_req.wdata = !released;
		end
	end

	always_comb begin
		res.kind       = kind;
		res.key_code   = is_scan ? base : 7'd0;
		res.char_value = is_scan ? ch : 7'd0;
		res.emit       = !is_scan ||
			(!is_prefix && !released && !prefix_q && in_table && (ch != 7'd0));
	end

	assign busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= 1'b0;
			shift_q    <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept && is_scan) begin
				if (is_prefix) begin
					prefix_q <= 1'b1;
				end else begin
					prefix_q <= 1'b0;
					shift_q  <= shift_nxt;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ps2_scancode_decoder.sv =====
// PS/2 scan code set 1 decoder. Takes one transaction per cycle, a scan code
// byte (kind 0) or a pressed-state query (kind 1), while the map is not being
// cleared and the output is not backed up. Key-down events and query answers pass
// through a stage register and an output register after acceptance, so a stalled
// output still lets the next transaction in while the stage register is free. The
// pressed-key map lives in a 256 x 1 synchronous RAM, which a query reads when it
// is accepted. After reset the block clears all 256 map entries, during which in_ready stays low.
`default_nettype none
module ps2_scancode_decoder
	import ps2sd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        kind,
	input  wire [7:0]  code_byte,
	input  wire [7:0]  query_key,
	input  wire [7:0]  tick_stamp,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       result_kind,
	output logic [6:0] key_code,
	output logic [6:0] char_value,
	output logic [7:0] event_time,
	output logic       is_down
);

	logic     busy;
	logic     accept;
	logic     adv_s1;
	map_req_t map_req;
	dec_res_t res;
	logic     map_rdata;

	logic       valid_s1;
	logic       kind_s1;
	logic [6:0] code_s1;
	logic [6:0] char_s1;
	logic [7:0] time_s1;

	logic       out_valid_q;
	logic       kind_q;
	logic [6:0] code_q;
	logic [6:0] char_q;
	logic [7:0] time_q;
	logic       down_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!valid_s1 || adv_s1);
	assign accept   = in_valid && in_ready;

	ps2sd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.code_byte (code_byte),
		.query_key (query_key),
		.busy      (busy),
		.map_req   (map_req),
		.res       (res)
	);

	ps2sd_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (map_req.we),
		.waddr (map_req.waddr),
		.wdata (map_req.wdata),
		.re    (map_req.re),
		.raddr (map_req.raddr),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= res.emit;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= res.kind;
			code_s1 <= res.key_code;
			char_s1 <= res.char_value;
			time_s1 <= (res.kind == KIND_SCAN) ? tick_stamp : 8'd0;
		end
		if (adv_s1) begin
			kind_q <= kind_s1;
			code_q <= code_s1;
			char_q <= char_s1;
			time_q <= time_s1;
			down_q <= (kind_s1 == KIND_QUERY) ? map_rdata : 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign key_code    = code_q;
	assign char_value  = char_q;
	assign event_time  = time_q;
	assign is_down     = down_q;

endmodule
`default_nettype wire

// ===== tb/ps2_scancode_decoder_tb.sv =====
`timescale 1ns / 1ps
module ps2_scancode_decoder_tb;
	import ps2sd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 500;

	typedef struct packed {
		logic       kind;
		logic [7:0] code_byte;
		logic [7:0] query_key;
		logic [7:0] tick_stamp;
	} scan_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [6:0] key_code;
		logic [6:0] char_value;
		logic [7:0] event_time;
		logic       is_down;
	} key_result_t;

	localparam logic [6:0] PLAIN_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h01,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h02, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h03, 7'h2A, 7'h04, 7'h20
	};

	localparam logic [6:0] SHIFT_KEYS [0:57] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h01,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h02, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h03, 7'h2A, 7'h04, 7'h20
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       kind = 1'b0;
	logic [7:0] code_byte = 8'h00;
	logic [7:0] query_key = 8'h00;
	logic [7:0] tick_stamp = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       result_kind;
	logic [6:0] key_code;
	logic [6:0] char_value;
	logic [7:0] event_time;
	logic       is_down;

	scan_item_t  pending_items[$];
	key_result_t expected_results[$];

	bit key_held [0:255];
	bit ext_armed = 1'b0;
	bit shift_on = 1'b0;

	int unsigned n_total = 0;
	int unsigned n_accepted = 0;
	int unsigned n_results = 0;
	int unsigned n_events = 0;
	int unsigned n_answers = 0;
	int unsigned n_fail = 0;
	int unsigned cycles = 0;
	int unsigned tx_seen = 0;
	int unsigned rx_seen = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          rx_hold = 1'b0;

	ps2_scancode_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.code_byte  (code_byte),
		.query_key  (query_key),
		.tick_stamp (tick_stamp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_kind(result_kind),
		.key_code   (key_code),
		.char_value (char_value),
		.event_time (event_time),
		.is_down    (is_down)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < 256; i++) key_held[i] = 1'b0;
	end

	function automatic int unsigned draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// updates the key map and flags; returns 1 when the transaction yields a result
	function automatic bit decode_key_item(input scan_item_t it, output key_result_t res);
		logic [6:0] base;
		logic       up;
		bit         was_ext;
		logic [6:0] ch;
		res = '0;
		if (it.kind == KIND_QUERY) begin
			res.result_kind = KIND_QUERY;
			res.is_down = key_held[it.query_key];
			return 1'b1;
		end
		if (it.code_byte == PREFIX_BYTE) begin
			ext_armed = 1'b1;
			return 1'b0;
		end
		was_ext = ext_armed;
		ext_armed = 1'b0;
		base = it.code_byte[6:0];
		up = it.code_byte[7];
		key_held[{was_ext, base}] = !up;
		if (!was_ext && (base == LSHIFT_CODE || base == RSHIFT_CODE)) shift_on = !up;
		if (up || was_ext || base >= 7'd58) return 1'b0;
		ch = shift_on ? SHIFT_KEYS[base] : PLAIN_KEYS[base];
		if (ch == 7'd0) return 1'b0;
		res.result_kind = KIND_SCAN;
		res.key_code = base;
		res.char_value = ch;
		res.event_time = it.tick_stamp;
		return 1'b1;
	endfunction

	task automatic add_scan(input logic [7:0] b, input logic [7:0] t);
		scan_item_t it;
		it.kind = KIND_SCAN;
		it.code_byte = b;
		it.query_key = 8'($urandom_range(0, 255));
		it.tick_stamp = t;
		pending_items.push_back(it);
	endtask

	task automatic add_query(input logic [7:0] q, input logic [7:0] t);
		scan_item_t it;
		it.kind = KIND_QUERY;
		it.code_byte = 8'($urandom_range(0, 255));
		it.query_key = q;
		it.tick_stamp = t;
		pending_items.push_back(it);
	endtask

	always @(negedge clk) begin : drive_items
		scan_item_t it;
		if (arst_n) begin
			if (!(in_valid && n_accepted == tx_seen)) begin
				tx_seen <= n_accepted;
				if (tx_wait != 0) begin
					in_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					kind <= it.kind;
					code_byte <= it.code_byte;
					query_key <= it.query_key;
					tick_stamp <= it.tick_stamp;
					in_valid <= 1'b1;
					tx_wait <= draw_wait(tx_calm);
					if ($urandom_range(0, 31) == 0) tx_calm <= ~tx_calm;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		int unsigned gap;
		if (arst_n) begin
			if (n_results != rx_seen) begin
				rx_seen <= n_results;
				gap = draw_wait(rx_calm);
				if ($urandom_range(0, 31) == 0) rx_calm <= ~rx_calm;
			end else begin
				gap = rx_wait;
			end
			if (rx_hold) begin
				out_ready <= 1'b0;
				rx_wait <= gap;
			end else if (gap != 0) begin
				out_ready <= 1'b0;
				rx_wait <= gap - 1;
			end else begin
				out_ready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin : check_and_predict
		key_result_t want;
		key_result_t got;
		scan_item_t  acc;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results <= n_results + 1;
				got = '{result_kind, key_code, char_value, event_time, is_down};
				if (got.result_kind == KIND_QUERY) n_answers++;
				else n_events++;
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected: result_kind %0d",
						got.result_kind);
					n_fail++;
				end else begin
					want = expected_results.pop_front();
					if (got.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, got %0d",
							want.result_kind, got.result_kind);
						n_fail++;
					end
					if (got.key_code !== want.key_code) begin
						$error("key_code: expected %0h, got %0h", want.key_code, got.key_code);
						n_fail++;
					end
					if (got.char_value !== want.char_value) begin
						$error("char_value: expected %0h, got %0h",
							want.char_value, got.char_value);
						n_fail++;
					end
					if (got.event_time !== want.event_time) begin
						$error("event_time: expected %0h, got %0h",
							want.event_time, got.event_time);
						n_fail++;
					end
					if (got.is_down !== want.is_down) begin
						$error("is_down: expected %0d, got %0d", want.is_down, got.is_down);
						n_fail++;
					end
				end
			end
			if (in_valid && in_ready) begin
				n_accepted <= n_accepted + 1;
				acc = '{kind, code_byte, query_key, tick_stamp};
				if (decode_key_item(acc, want)) expected_results.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// long receiver stall so the block fills and backs up its input
	initial begin : receiver_hold
		while (n_accepted < 120) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : run_control
		logic [6:0] base;
		logic [6:0] sh;
		int unsigned presses;

		add_query(8'h00, 8'h00);
		add_query(8'hFF, 8'hFF);
		add_scan(8'h00, 8'h12);
		add_scan(8'h1E, 8'hFF);
		add_scan({1'b0, LSHIFT_CODE}, 8'h00);
		add_scan(8'h1E, 8'h34);
		add_scan(8'h02, 8'h56);
		add_scan({1'b1, LSHIFT_CODE}, 8'h78);
		add_scan({1'b0, RSHIFT_CODE}, 8'h9A);
		add_scan(8'h39, 8'hBC);
		add_scan({1'b1, RSHIFT_CODE}, 8'hDE);
		add_scan(8'h3A, 8'h01);
		add_scan(8'h7F, 8'h02);
		add_scan(8'hFF, 8'h03);
		add_scan(PREFIX_BYTE, 8'h04);
		add_scan(PREFIX_BYTE, 8'h05);
		add_query(8'h1D, 8'h06);
		add_scan({1'b0, LSHIFT_CODE}, 8'h07);
		add_scan(8'h10, 8'h08);
		add_query(8'hAA, 8'h09);
		add_scan(PREFIX_BYTE, 8'h0A);
		add_scan({1'b1, LSHIFT_CODE}, 8'h0B);
		add_query(8'hAA, 8'h0C);
		add_scan(8'h80, 8'h0D);
		add_query(8'h00, 8'h0E);
		add_query(8'h1E, 8'h0F);

		while (pending_items.size() < 26 + RANDOM_ITEMS) begin
			base = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 57)) :
				7'($urandom_range(58, 127));
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					add_scan({1'b0, base}, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) add_query({1'b0, base}, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) add_scan({1'b1, base}, 8'($urandom_range(0, 255)));
				end
				3: begin
					sh = $urandom_range(0, 1) ? LSHIFT_CODE : RSHIFT_CODE;
					add_scan({1'b0, sh}, 8'($urandom_range(0, 255)));
					presses = $urandom_range(1, 3);
					repeat (presses)
						add_scan(8'($urandom_range(0, 57)), 8'($urandom_range(0, 255)));
					add_scan({1'b1, sh}, 8'($urandom_range(0, 255)));
				end
				4: begin
					add_scan(PREFIX_BYTE, 8'($urandom_range(0, 255)));
					add_scan({1'b0, base}, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) add_query({1'b1, base}, 8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1)) begin
						add_scan(PREFIX_BYTE, 8'($urandom_range(0, 255)));
						add_scan({1'b1, base}, 8'($urandom_range(0, 255)));
					end
				end
				5, 6: add_query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				7: add_scan({1'b1, base}, 8'($urandom_range(0, 255)));
				8: add_scan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				default: begin
					add_scan(PREFIX_BYTE, 8'($urandom_range(0, 255)));
					add_query(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					add_scan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			endcase
		end
		n_total = pending_items.size();

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (n_accepted != n_total || expected_results.size() != 0);
		repeat (8) @(negedge clk);

		$display("covered %0d transactions in, %0d key-down events and %0d query answers out",
			n_accepted, n_events, n_answers);
		$display("with shift, extended prefix, release and query mixes and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (n_fail == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
